>>> rtl/deq_pkg.sv
// Shared constants, types and ring index helpers for the double-ended queue.
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [VALUE_W-1:0]    value_t;

	typedef enum logic [2:0] {
		FUNC_PUSH_FRONT = 3'd0,
		FUNC_PUSH_BACK  = 3'd1,
		FUNC_POP_FRONT  = 3'd2,
		FUNC_POP_BACK   = 3'd3,
		FUNC_STATUS     = 3'd4
	} func_t;

	function automatic idx_t idx_inc(input idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic idx_t idx_dec(input idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

>>> rtl/deq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module deq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH_P-1:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/double_ended_queue.sv
// Bounded double-ended queue: ring storage in a RAM with cached front and rear words.
// An accepted command moves control from the idle to the response state, where its result
// is registered and strobed by done. Start is ignored while busy, which is high for the one cycle
// in which the RAM read for a pop returns and the cached front or rear word is refilled from it.
// Reset clears the indices, the entry count and the control state; the storage is not cleared.
// Results cannot be stalled: done is high for exactly one cycle per command.
module double_ended_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            func,
	input  deq_pkg::value_t       value,
	output logic                  done,
	output logic                  ok,
	output deq_pkg::value_t       popped_value,
	output deq_pkg::value_t       front_value,
	output deq_pkg::value_t       rear_value,
	output deq_pkg::cnt_t         count,
	output logic                  is_empty
);

	import deq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RESP = 2'b10
	} state_t;

	state_t state_q;
	idx_t   head_q, tail_q, head_d, tail_d;
	cnt_t   cnt_q, cnt_d;
	data_t  front_q, rear_q, front_d, rear_d;
	data_t  val, pop_d, rdata, front_res, rear_res;
	logic   acc, full, empty;
	logic   mem_we, mem_re;
	idx_t   mem_waddr, mem_raddr;
	logic   ok_d, fixf_d, fixr_d;
	logic   ok_s1, fixf_s1, fixr_s1;
	data_t  pop_s1;
	logic   done_q, ok_q, empty_q;
	value_t popped_q, front_out_q, rear_out_q;
	cnt_t   count_q;

	assign busy  = (state_q == ST_RESP);
	assign acc   = start && !busy;
	assign full  = (cnt_q == cnt_t'(DEPTH));
	assign empty = (cnt_q == '0);
	assign val   = data_t'(value);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		front_d   = front_q;
		rear_d    = rear_q;
		ok_d      = 1'b1;
		pop_d     = '0;
		fixf_d    = 1'b0;
		fixr_d    = 1'b0;
		unique case (func_t'(func))
			FUNC_PUSH_FRONT: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					head_d    = idx_dec(head_q);
					mem_we    = 1'b1;
					mem_waddr = head_d;
					front_d   = val;
					if (empty) begin
						rear_d = val;
					end
					cnt_d = cnt_q + 1'b1;
				end
			end
			FUNC_PUSH_BACK: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = tail_q;
					tail_d    = idx_inc(tail_q);
					rear_d    = val;
					if (empty) begin
						front_d = val;
					end
					cnt_d = cnt_q + 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					pop_d  = front_q;
					head_d = idx_inc(head_q);
					cnt_d  = cnt_q - 1'b1;
					// The new front word lives in the RAM unless the queue drains.
					if (cnt_q != cnt_t'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = head_d;
						fixf_d    = 1'b1;
					end
				end
			end
			FUNC_POP_BACK: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					pop_d  = rear_q;
					tail_d = idx_dec(tail_q);
					cnt_d  = cnt_q - 1'b1;
					if (cnt_q != cnt_t'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = idx_dec(tail_d);
						fixr_d    = 1'b1;
					end
				end
			end
			default: begin
				ok_d = 1'b1;
			end
		endcase
	end

	deq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (acc && mem_we),
		.waddr (mem_waddr),
		.wdata (val),
		.re    (acc && mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign front_res = fixf_s1 ? rdata : front_q;
	assign rear_res  = fixr_s1 ? rdata : rear_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						cnt_q   <= cnt_d;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			ok_s1   <= ok_d;
			pop_s1  <= pop_d;
			fixf_s1 <= fixf_d;
			fixr_s1 <= fixr_d;
		end else if (busy) begin
			front_q     <= front_res;
			rear_q      <= rear_res;
			ok_q        <= ok_s1;
			popped_q    <= value_t'(pop_s1);
			front_out_q <= (cnt_q == '0) ? '0 : value_t'(front_res);
			rear_out_q  <= (cnt_q == '0) ? '0 : value_t'(rear_res);
			count_q     <= cnt_q;
			empty_q     <= (cnt_q == '0);
		end
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign popped_value = popped_q;
	assign front_value  = front_out_q;
	assign rear_value   = rear_out_q;
	assign count        = count_q;
	assign is_empty     = empty_q;

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not enter the response cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding response cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(DEPTH))
		else $error("entry count exceeds depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (count == '0)))
		else $error("empty flag disagrees with count");

endmodule
